### sv/lane_edge_extent_extrapolator_top_macros.svh
// ----------------------------------------------------------------------------
// lane edge extent extrapolator assertion macros
// clocked assertion helpers used by leex_back
// ----------------------------------------------------------------------------
`ifndef LANE_EDGE_EXTENT_EXTRAPOLATOR_TOP_MACROS_SVH
`define LANE_EDGE_EXTENT_EXTRAPOLATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define LEEX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("leex assertion failed");
// property checked on every rising clock edge, reset included
`define LEEX_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("leex assertion failed");
`else
`define LEEX_ASSERT(lbl, clk, rst, prop)
`define LEEX_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/leex_pkg.sv
// ----------------------------------------------------------------------------
// leex_pkg
// shared types and constants of the lane edge extent extrapolator
// ----------------------------------------------------------------------------
package leex_pkg;

   // item and port widths
   localparam int PIX_W       = 8;
   localparam int DIM_CFG_W   = 12;
   localparam int UPPER_CFG_W = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int XY_W        = 11;
   localparam int BX_W        = 13;
   localparam int TDATA_W     = 72;
   localparam int TUSER_W     = 2;
   localparam int PAD_W       = TDATA_W - 2 * (2 * XY_W + BX_W);

   // reset values of the configuration registers
   localparam int RESET_WIDTH  = 960;
   localparam int RESET_HEIGHT = 540;
   localparam int RESET_UPPER  = 330;

   // saturation range of the extrapolated column
   localparam int OUT_MAX = 4095;
   localparam int OUT_MIN = -4096;

   // frame records buffered between scanner and solver
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_UPPER_LIMIT  = 2'd2
   } csr_index_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### sv/leex_queue.sv
// ----------------------------------------------------------------------------
// leex_queue
// small register queue carrying frame records from scanner to solver
// ----------------------------------------------------------------------------
module leex_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output leex_pkg::queue_status_type status
);
   import leex_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   // head entry shown ahead
   assign rdata        = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### sv/leex_front.sv
// ----------------------------------------------------------------------------
// leex_front
// pixel scanner: counts rows and columns, keeps per-half hit points and
// hands one classified frame record to the queue at each frame end
// ----------------------------------------------------------------------------
module leex_front #(
   parameter int COORD_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [leex_pkg::DIM_CFG_W-1:0]      cfg_width,
   input  logic [leex_pkg::DIM_CFG_W-1:0]      cfg_height,
   input  logic [leex_pkg::UPPER_CFG_W-1:0]    cfg_upper,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [leex_pkg::PIX_W-1:0]          req_pixel,
   input  leex_pkg::queue_status_type          q_status,
   output logic                                push,
   output logic [9*COORD_BITS+2:0]             rec
);
   import leex_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int DW     = C + 1;
   localparam int WW     = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
   localparam int UW     = (C > UPPER_CFG_W) ? C : UPPER_CFG_W;
   localparam int HALF_W = 4 * C + 1;
   localparam int REC_W  = 2 * HALF_W + DW;
   localparam logic [WW-1:0] MAX_DIM = WW'(1) << C;
   localparam logic [WW-1:0] MIN_W   = WW'(2);
   localparam logic [WW-1:0] MIN_H   = WW'(1);

   logic [C-1:0] col_ff, row_ff;
   logic [1:0]   hit_v_ff, hit_v_in;
   logic [C-1:0] hit_col_ff [2];
   logic [C-1:0] hit_col_in [2];
   logic [1:0]   top_found_ff, top_found_in;
   logic [1:0]   bot_found_ff, bot_found_in;
   logic [C-1:0] top_x_ff [2];
   logic [C-1:0] top_y_ff [2];
   logic [C-1:0] bot_x_ff [2];
   logic [C-1:0] bot_y_ff [2];
   logic [C-1:0] top_x_in [2];
   logic [C-1:0] top_y_in [2];
   logic [C-1:0] bot_x_in [2];
   logic [C-1:0] bot_y_in [2];
   logic [1:0]   half_ok;

   logic [WW-1:0] wide_w, wide_h;
   logic [DW-1:0] eff_w, eff_h;
   logic [C-1:0]  half_w;
   logic          last_col, last_row, frame_end, accept, side;
   logic          row_ge, row_gt;

   // clamp the frame size to the coordinate range
   always_comb begin
      wide_w = WW'(cfg_width);
      wide_h = WW'(cfg_height);
      if (wide_w < MIN_W) begin
         eff_w = DW'(MIN_W);
      end else if (wide_w > MAX_DIM) begin
         eff_w = DW'(MAX_DIM);
      end else begin
         eff_w = DW'(wide_w);
      end
      if (wide_h < MIN_H) begin
         eff_h = DW'(MIN_H);
      end else if (wide_h > MAX_DIM) begin
         eff_h = DW'(MAX_DIM);
      end else begin
         eff_h = DW'(wide_h);
      end
   end

   // position of the current pixel
   assign half_w    = eff_w[DW-1:1];
   assign side      = !(col_ff < half_w);
   assign last_col  = ({1'b0, col_ff} >= (eff_w - DW'(1)));
   assign last_row  = ({1'b0, row_ff} >= (eff_h - DW'(1)));
   assign frame_end = last_col && last_row;
   assign row_ge    = (UW'(row_ff) >= UW'(cfg_upper));
   assign row_gt    = (UW'(row_ff) > UW'(cfg_upper));

   // only the last pixel of a frame needs room in the queue
   assign req_ready = !frame_end || !q_status.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && frame_end;

   // hit tracking and end-of-row point update per half
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         hit_v_in[s]   = hit_v_ff[s];
         hit_col_in[s] = hit_col_ff[s];
         if ((req_pixel != '0) && (side == 1'(s))) begin
            hit_v_in[s]   = 1'b1;
            hit_col_in[s] = col_ff;
         end
         top_found_in[s] = top_found_ff[s];
         top_x_in[s]     = top_x_ff[s];
         top_y_in[s]     = top_y_ff[s];
         bot_found_in[s] = bot_found_ff[s];
         bot_x_in[s]     = bot_x_ff[s];
         bot_y_in[s]     = bot_y_ff[s];
         if (hit_v_in[s] && row_ge && !top_found_ff[s]) begin
            top_found_in[s] = 1'b1;
            top_x_in[s]     = hit_col_in[s];
            top_y_in[s]     = row_ff;
         end
         if (hit_v_in[s] && row_gt) begin
            bot_found_in[s] = 1'b1;
            bot_x_in[s]     = hit_col_in[s];
            bot_y_in[s]     = row_ff;
         end
         half_ok[s] = top_found_in[s] && bot_found_in[s] && (top_y_in[s] != bot_y_in[s]);
      end
   end

   // frame record: per half {ok, bottom y, bottom x, top y, top x}, height on top
   always_comb begin
      rec = '0;
      for (int s = 0; s < 2; s++) begin
         rec[s*HALF_W +: HALF_W] = {half_ok[s], bot_y_in[s], bot_x_in[s],
                                    top_y_in[s], top_x_in[s]};
      end
      rec[REC_W-1 -: DW] = eff_h;
   end

   // counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         hit_v_ff     <= '0;
         top_found_ff <= '0;
         bot_found_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff   <= '0;
            hit_v_ff <= '0;
            if (last_row) begin
               row_ff       <= '0;
               top_found_ff <= '0;
               bot_found_ff <= '0;
            end else begin
               row_ff       <= row_ff + C'(1);
               top_found_ff <= top_found_in;
               bot_found_ff <= bot_found_in;
            end
         end else begin
            col_ff   <= col_ff + C'(1);
            hit_v_ff <= hit_v_in;
         end
      end
   end

   // hit columns and points
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int s = 0; s < 2; s++) begin
            hit_col_ff[s] <= hit_col_in[s];
            if (last_col && !last_row) begin
               top_x_ff[s] <= top_x_in[s];
               top_y_ff[s] <= top_y_in[s];
               bot_x_ff[s] <= bot_x_in[s];
               bot_y_ff[s] <= bot_y_in[s];
            end
         end
      end
   end

endmodule

### sv/leex_back.sv
// ----------------------------------------------------------------------------
// leex_back
// line solver: takes frame records from the queue, extrapolates each half
// with a multiply and a restoring divider, and drives the result register
// ----------------------------------------------------------------------------
`include "lane_edge_extent_extrapolator_top_macros.svh"

module leex_back #(
   parameter int COORD_BITS = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [9*COORD_BITS+2:0]           rec,
   input  leex_pkg::queue_status_type        q_status,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [leex_pkg::TDATA_W-1:0]      rsp_data,
   output logic [leex_pkg::TUSER_W-1:0]      rsp_user
);
   import leex_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int DW     = C + 1;
   localparam int HALF_W = 4 * C + 1;
   localparam int REC_W  = 2 * HALF_W + DW;
   localparam int PW     = 2 * C + 3;
   localparam int NW     = PW - 1;
   localparam int SW     = NW + 2;
   localparam int CW     = $clog2(NW + 1);
   localparam logic signed [SW-1:0] X_MAX = SW'(OUT_MAX);
   localparam logic signed [SW-1:0] X_MIN = SW'(OUT_MIN);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_ABS  = 6'b000100,
      S_DIV  = 6'b001000,
      S_FIN  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [REC_W-1:0]       rec_ff;
   logic                   half_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [DW-1:0]   dy_ff;
   logic [NW-1:0]          num_ff;
   logic [C-1:0]           den_ff;
   logic [C-1:0]           rem_ff;
   logic                   neg_ff;
   logic [CW-1:0]          cnt_ff;
   logic [XY_W-1:0]        res_tx_ff [2];
   logic [XY_W-1:0]        res_ty_ff [2];
   logic [BX_W-1:0]        res_bx_ff [2];
   logic [1:0]             res_ok_ff;
   logic                   rsp_valid_ff;
   logic [TDATA_W-1:0]     rsp_data_ff;
   logic [TUSER_W-1:0]     rsp_user_ff;

   logic [HALF_W-1:0]      cur;
   logic [C-1:0]           cur_xt, cur_yt, cur_xb, cur_yb;
   logic                   cur_ok;
   logic [DW-1:0]          cur_h;
   logic signed [C+1:0]    dh;
   logic signed [DW-1:0]   dx, dy;
   logic signed [PW-1:0]   prod_in;
   logic [DW-1:0]          rem_sh;
   logic                   q_bit;
   logic [C-1:0]           rem_in;
   logic signed [SW-1:0]   sq, x_sum, x_sat;
   logic                   rsp_load;

   // current half of the record
   assign cur    = half_ff ? rec_ff[2*HALF_W-1:HALF_W] : rec_ff[HALF_W-1:0];
   assign cur_xt = cur[C-1:0];
   assign cur_yt = cur[2*C-1:C];
   assign cur_xb = cur[3*C-1:2*C];
   assign cur_yb = cur[4*C-1:3*C];
   assign cur_ok = cur[4*C];
   assign cur_h  = rec_ff[REC_W-1 -: DW];

   // differences and product (height - y_top) * (x_top - x_bottom)
   assign dh      = $signed({1'b0, cur_h}) - $signed({2'b00, cur_yt});
   assign dx      = $signed({1'b0, cur_xt}) - $signed({1'b0, cur_xb});
   assign dy      = $signed({1'b0, cur_yt}) - $signed({1'b0, cur_yb});
   assign prod_in = dh * dx;

   // one restoring divider step
   always_comb begin
      rem_sh = {rem_ff, num_ff[NW-1]};
      q_bit  = (rem_sh >= {1'b0, den_ff});
      rem_in = q_bit ? C'(rem_sh - {1'b0, den_ff}) : C'(rem_sh);
   end

   // signed quotient added to the top column, then saturated
   always_comb begin
      sq    = neg_ff ? -$signed({2'b00, num_ff}) : $signed({2'b00, num_ff});
      x_sum = $signed({{(SW-C){1'b0}}, cur_xt}) + sq;
      if (x_sum > X_MAX) begin
         x_sat = X_MAX;
      end else if (x_sum < X_MIN) begin
         x_sat = X_MIN;
      end else begin
         x_sat = x_sum;
      end
   end

   // sequencer
   assign pop      = (state_ff == S_IDLE) && !q_status.empty;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = cur_ok ? S_ABS : S_FIN;
         end
         S_ABS: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = half_ff ? S_OUT : S_MUL;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               rec_ff  <= rec;
               half_ff <= 1'b0;
            end
         end
         S_MUL: begin
            prod_ff <= prod_in;
            dy_ff   <= dy;
         end
         S_ABS: begin
            num_ff <= prod_ff[PW-1] ? NW'(-prod_ff) : NW'(prod_ff);
            den_ff <= dy_ff[DW-1] ? C'(-dy_ff) : C'(dy_ff);
            neg_ff <= prod_ff[PW-1] ^ dy_ff[DW-1];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         S_DIV: begin
            num_ff <= {num_ff[NW-2:0], q_bit};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + CW'(1);
         end
         S_FIN: begin
            if (cur_ok) begin
               res_tx_ff[half_ff] <= XY_W'({{XY_W{1'b0}}, cur_xt});
               res_ty_ff[half_ff] <= XY_W'({{XY_W{1'b0}}, cur_yt});
               res_bx_ff[half_ff] <= BX_W'(x_sat);
               res_ok_ff[half_ff] <= 1'b1;
            end else begin
               res_tx_ff[half_ff] <= '0;
               res_ty_ff[half_ff] <= '0;
               res_bx_ff[half_ff] <= '0;
               res_ok_ff[half_ff] <= 1'b0;
            end
            half_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, res_bx_ff[1], res_ty_ff[1], res_tx_ff[1],
                         res_bx_ff[0], res_ty_ff[0], res_tx_ff[0]};
         rsp_user_ff <= {res_ok_ff[1], res_ok_ff[0]};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_user  = rsp_user_ff;

   // checks
   `LEEX_ASSERT(a_div_count, clock, reset, (state_ff == S_DIV) |-> (cnt_ff < CW'(NW)))
   `LEEX_ASSERT(a_rem_below_den, clock, reset, ((state_ff == S_FIN) && cur_ok) |-> (rem_ff < den_ff))
   `LEEX_ASSERT(a_load_free, clock, reset, rsp_load |-> (!rsp_valid_ff || rsp_ready))
   `LEEX_ASSERT(a_pop_nonempty, clock, reset, pop |-> !q_status.empty)

endmodule

### sv/lane_edge_extent_extrapolator_top.sv
// ----------------------------------------------------------------------------
// lane_edge_extent_extrapolator_top
// Edge-map frames enter on req_ one 8-bit pixel per item in raster order.
// After the last pixel of a frame one result leaves on rsp_: top point of
// the left and right half and the column where each half's line meets the
// image height, with an ok flag per half in rsp_tuser.
// Throughput: one pixel per cycle while the queue has room. Per half the
// solver runs a multiply, an absolute-value step, the bit-serial divider and
// a finish step; a half without a line goes from the multiply to the finish
// step. Then the result register loads. A two-entry queue holds frame records,
// so the scanner keeps taking pixels while the solver works and while a
// result waits; only the last pixel of a frame waits for a free queue entry.
// The result register holds while rsp_tready is low. Configuration (csr_we,
// csr_index, csr_wdata) must be written only between frames; the block
// does not enforce this. Reset is synchronous: counters, flags and queue
// clear, registers return to width 960, height 540, upper limit 330.
// ----------------------------------------------------------------------------
module lane_edge_extent_extrapolator_top #(
   parameter int COORD_BITS = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   // pixel item: [7:0] pixel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [leex_pkg::PIX_W-1:0]         req_tdata,
   // result: [10:0] left_top_x, [21:11] left_top_y, [34:22] left_bottom_x,
   // [45:35] right_top_x, [56:46] right_top_y, [69:57] right_bottom_x
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [leex_pkg::TDATA_W-1:0]       rsp_tdata,
   // flags: [0] left_ok, [1] right_ok
   output logic [leex_pkg::TUSER_W-1:0]       rsp_tuser,
   input  logic                               csr_we,
   input  logic [leex_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [leex_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import leex_pkg::*;

   localparam int REC_W = 9 * COORD_BITS + 3;

   logic [DIM_CFG_W-1:0]   image_width_ff;
   logic [DIM_CFG_W-1:0]   image_height_ff;
   logic [UPPER_CFG_W-1:0] upper_limit_ff;
   logic                   push, pop;
   logic [REC_W-1:0]       rec_wdata, rec_rdata;
   queue_status_type       q_status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_CFG_W'(RESET_WIDTH);
         image_height_ff <= DIM_CFG_W'(RESET_HEIGHT);
         upper_limit_ff  <= UPPER_CFG_W'(RESET_UPPER);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= DIM_CFG_W'(csr_wdata);
            CSR_IMAGE_HEIGHT: image_height_ff <= DIM_CFG_W'(csr_wdata);
            CSR_UPPER_LIMIT:  upper_limit_ff  <= UPPER_CFG_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // pixel scanner
   leex_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (image_width_ff),
      .cfg_height (image_height_ff),
      .cfg_upper  (upper_limit_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_pixel  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .rec        (rec_wdata)
   );

   // frame record queue
   leex_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (rec_wdata),
      .pop    (pop),
      .rdata  (rec_rdata),
      .status (q_status)
   );

   // line solver
   leex_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec       (rec_rdata),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_user  (rsp_tuser)
   );

endmodule
